>>> hdl/bcls_pkg.sv
// Shared types, constants and opcode table for the bytecode length and leader scanner.
`default_nettype none
package bcls_pkg;

    localparam int OFS_W  = 24;
    localparam int ROM_SIZE = 181;

    localparam logic [2:0] KIND_UNK = 3'd0;
    localparam logic [2:0] KIND_FIX = 3'd1;
    localparam logic [2:0] KIND_STR = 3'd2;
    localparam logic [2:0] KIND_BLK = 3'd3;
    localparam logic [2:0] KIND_SW  = 3'd4;

    localparam logic [7:0] OP_JMP_FIRST = 8'd25;
    localparam logic [7:0] OP_JMP_LAST  = 8'd33;
    localparam logic [7:0] OP_JMP_SW_LAST = 8'd27;
    localparam logic [7:0] SW_LIT_NUM = 8'd97;
    localparam logic [7:0] SW_LIT_STR = 8'd106;
    localparam logic [7:0] SW_LIT_NIL = 8'd100;
    localparam logic [7:0] SW_JMP_BIAS = 8'd24;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNKNOWN   = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_BAD_TGT   = 3'd3,
        ST_BAD_SW    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_OPC      = 4'd0,
        PH_OPND     = 4'd1,
        PH_HDR      = 4'd2,
        PH_SKIP     = 4'd3,
        PH_SWLIT    = 4'd4,
        PH_SWLSKIP  = 4'd5,
        PH_SWSTRLEN = 4'd6,
        PH_SWJMP    = 4'd7,
        PH_SWJSKIP  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [OFS_W-1:0] pos;
        logic [OFS_W-1:0] start;
        logic [7:0]       opc;
        phase_t           phase;
        logic [OFS_W-1:0] acc;
        logic [OFS_W-1:0] left;
        logic [15:0]      cases;
        logic             sup_flag;
        logic             stopped;
    } scan_state_t;

    typedef struct packed {
        logic [OFS_W-1:0] instr_offset;
        logic [7:0]       opcode;
        logic [OFS_W-1:0] instr_length;
        logic             supported;
        logic             is_jump;
        logic [OFS_W-1:0] jump_target;
        logic             mark_target;
        logic             mark_fallthrough;
        status_t          status;
        logic             done_res;
        logic             all_supported;
    } scan_result_t;

    // Bits 3:0 fixed length or header size, bits 6:4 length kind, bit 7 supported.
    localparam logic [7:0] OP_ROM [0:ROM_SIZE-1] = '{
        8'h91,8'h91,8'h91,8'h93,8'h93,8'h91,8'h11,8'h91,8'h91,8'h91,
        8'h91,8'h93,8'h92,8'h93,8'h91,8'h91,8'h91,8'h91,8'h91,8'h93,
        8'h92,8'h91,8'h19,8'h91,8'h11,8'h92,8'h93,8'h94,8'h92,8'h93,
        8'h94,8'h92,8'h93,8'h94,8'h91,8'h91,8'h93,8'h00,8'h92,8'h92,
        8'h92,8'h93,8'h92,8'h91,8'h92,8'h92,8'h91,8'h91,8'h93,8'h91,
        8'h91,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h32,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h91,8'h91,8'h91,8'h91,8'h91,
        8'h91,8'h14,8'h91,8'h91,8'h91,8'h93,8'h92,8'h93,8'h93,8'h93,
        8'h92,8'h93,8'h93,8'h93,8'h91,8'h91,8'h93,8'h92,8'h93,8'hB2,
        8'hB1,8'h93,8'h92,8'h93,8'h93,8'h92,8'h93,8'h95,8'h93,8'h93,
        8'h91,8'h9B,8'h91,8'h93,8'h93,8'hA2,8'hA1,8'h93,8'h92,8'h93,
        8'h91,8'h93,8'h92,8'h14,8'h14,8'h11,8'h13,8'h15,8'h00,8'h91,
        8'h91,8'h91,8'h91,8'h93,8'h93,8'h22,8'h94,8'h91,8'h99,8'h93,
        8'h91,8'h91,8'h91,8'hC2,8'h15,8'h91,8'h91,8'h91,8'h91,8'h91,
        8'h91,8'h91,8'h91,8'h91,8'h93,8'h91,8'h93,8'h91,8'h91,8'h13,
        8'h14,8'h14,8'h00,8'h95,8'h91,8'h91,8'h91,8'h91,8'h91,8'h33,
        8'h23,8'hB3,8'hA3,8'h12,8'h11,8'h91,8'h14,8'h14,8'h11,8'h91,
        8'h91,8'h91,8'h91,8'h93,8'h93,8'h93,8'h93,8'h93,8'h11,8'h00,
        8'h91
    };

    function automatic logic [7:0] rom_entry(input logic [7:0] op);
        logic [7:0] e;
        e = 8'h00;
        if (op < 8'(ROM_SIZE)) begin
            e = OP_ROM[op];
        end
        return e;
    endfunction

endpackage
`default_nettype wire

>>> hdl/bcls_step.sv
// Combinational decode of one bytecode byte: next scan state and the result it produces.
`default_nettype none
module bcls_step (
    input  wire bcls_pkg::scan_state_t  cur,
    input  wire [7:0]                   code_byte,
    input  wire [bcls_pkg::OFS_W-1:0]   code_size,
    output bcls_pkg::scan_state_t       nxt,
    output logic                        has_result,
    output bcls_pkg::scan_result_t      res
);
    import bcls_pkg::*;

    logic [OFS_W:0]   pos_p1;
    logic             last;
    logic [OFS_W-1:0] start;
    logic [7:0]       op;
    logic [7:0]       info;
    logic [2:0]       kind;
    logic [3:0]       hsz;
    logic             sup;
    logic             jmp;
    logic             complete;
    status_t          st;
    logic [1:0]       idx;
    logic [OFS_W-1:0] acc_new;
    logic [OFS_W-1:0] left_dec;
    logic [OFS_W+1:0] sum_w;
    logic [OFS_W+1:0] disp;
    logic [OFS_W+1:0] tgt;
    logic [OFS_W-1:0] len;
    logic             mt;
    logic             mf;
    logic             sup_next;

    always_comb begin
        pos_p1 = {1'b0, cur.pos} + 1'b1;
        last   = (pos_p1 == {1'b0, code_size});
        start  = (cur.phase == PH_OPC) ? cur.pos : cur.start;
        op     = (cur.phase == PH_OPC) ? code_byte : cur.opc;
        info   = rom_entry(op);
        kind   = info[6:4];
        sup    = info[7];
        hsz    = info[3:0];
        if (kind == KIND_FIX) begin
            hsz = info[3:0] - 4'd1;
        end else if (kind == KIND_SW) begin
            hsz = 4'd2;
        end
        jmp = (op >= OP_JMP_FIRST) && (op <= OP_JMP_LAST);

        nxt       = cur;
        nxt.pos   = pos_p1[OFS_W-1:0];
        nxt.start = start;
        nxt.opc   = op;
        complete  = 1'b0;
        st        = ST_OK;
        idx       = 2'(hsz - 4'(cur.left[3:0]));
        acc_new   = cur.acc | (OFS_W'(code_byte) << (5'd8 * 5'(idx)));
        left_dec  = cur.left - 1'b1;
        sum_w     = '0;

        unique case (cur.phase)
            PH_OPC: begin
                nxt.acc = '0;
                if (kind == KIND_UNK || kind > KIND_SW) begin
                    st = ST_UNKNOWN;
                end else if (kind == KIND_FIX) begin
                    sum_w = {2'b0, start} + (OFS_W+2)'(hsz) + 1'b1;
                    if (sum_w > {2'b0, code_size}) begin
                        st = ST_TRUNCATED;
                    end else if (hsz == 4'd0) begin
                        complete = 1'b1;
                    end else begin
                        nxt.phase = PH_OPND;
                        nxt.left  = OFS_W'(hsz);
                    end
                end else begin
                    nxt.phase = PH_HDR;
                    nxt.left  = OFS_W'(hsz);
                end
            end
            PH_OPND, PH_HDR: begin
                nxt.acc  = acc_new;
                nxt.left = left_dec;
                if (left_dec == '0) begin
                    if (cur.phase == PH_OPND) begin
                        complete = 1'b1;
                    end else if (kind == KIND_STR) begin
                        sum_w = {2'b0, start} + 1'b1 + (OFS_W+2)'(hsz) + {2'b0, acc_new};
                        if (sum_w > {2'b0, code_size}) begin
                            st = ST_TRUNCATED;
                        end else if (acc_new == '0) begin
                            complete = 1'b1;
                        end else begin
                            nxt.phase = PH_SKIP;
                            nxt.left  = acc_new;
                        end
                    end else if (kind == KIND_BLK) begin
                        sum_w = {2'b0, start} + {2'b0, acc_new};
                        if (acc_new < OFS_W'(hsz) + 1'b1) begin
                            st = ST_UNKNOWN;
                        end else if (sum_w > {2'b0, code_size}) begin
                            st = ST_TRUNCATED;
                        end else if (acc_new == OFS_W'(hsz) + 1'b1) begin
                            complete = 1'b1;
                        end else begin
                            nxt.phase = PH_SKIP;
                            nxt.left  = acc_new - 1'b1 - OFS_W'(hsz);
                        end
                    end else begin
                        nxt.cases = acc_new[15:0];
                        if (acc_new[15:0] == 16'd0) begin
                            complete = 1'b1;
                        end else begin
                            nxt.phase = PH_SWLIT;
                        end
                    end
                end
            end
            PH_SKIP: begin
                nxt.left = left_dec;
                complete = (left_dec == '0);
            end
            PH_SWLIT: begin
                if (code_byte == SW_LIT_NUM) begin
                    nxt.phase = PH_SWLSKIP;
                    nxt.left  = OFS_W'(4);
                end else if (code_byte == SW_LIT_STR) begin
                    nxt.phase = PH_SWSTRLEN;
                end else if (code_byte == SW_LIT_NIL) begin
                    nxt.phase = PH_SWJMP;
                end else begin
                    st = ST_BAD_SW;
                end
            end
            PH_SWLSKIP: begin
                nxt.left = left_dec;
                if (left_dec == '0) begin
                    nxt.phase = PH_SWJMP;
                end
            end
            PH_SWSTRLEN: begin
                if (code_byte == 8'd0) begin
                    nxt.phase = PH_SWJMP;
                end else begin
                    nxt.phase = PH_SWLSKIP;
                    nxt.left  = OFS_W'(code_byte);
                end
            end
            PH_SWJMP: begin
                if (code_byte >= OP_JMP_FIRST && code_byte <= OP_JMP_SW_LAST) begin
                    nxt.phase = PH_SWJSKIP;
                    nxt.left  = OFS_W'(code_byte - SW_JMP_BIAS);
                end else begin
                    st = ST_BAD_SW;
                end
            end
            PH_SWJSKIP: begin
                nxt.left = left_dec;
                if (left_dec == '0) begin
                    nxt.cases = cur.cases - 1'b1;
                    if (cur.cases == 16'd1) begin
                        complete = 1'b1;
                    end else begin
                        nxt.phase = PH_SWLIT;
                    end
                end
            end
            default: st = ST_UNKNOWN;
        endcase

        // Running out of code in the middle of an instruction.
        if (st == ST_OK && !complete && last) begin
            st = ST_TRUNCATED;
        end

        // Displacement width follows the operand size of the jump opcode.
        unique case (hsz[1:0])
            2'd1:    disp = {{(OFS_W-6){nxt.acc[7]}}, nxt.acc[7:0]};
            2'd2:    disp = {{(OFS_W-14){nxt.acc[15]}}, nxt.acc[15:0]};
            2'd3:    disp = {{2{nxt.acc[OFS_W-1]}}, nxt.acc};
            default: disp = '0;
        endcase
        tgt = {2'b0, start} + disp;
        len = pos_p1[OFS_W-1:0] - start;
        mt  = 1'b0;
        mf  = 1'b0;
        // The target is only checked once the whole displacement has arrived.
        if (st == ST_OK && complete && jmp) begin
            if (tgt[OFS_W+1] || tgt[OFS_W:0] > {1'b0, code_size}) begin
                st = ST_BAD_TGT;
            end else begin
                mt = tgt[OFS_W:0] < {1'b0, code_size};
                mf = pos_p1 < {1'b0, code_size};
            end
        end

        has_result = (st != ST_OK) || complete;
        sup_next   = cur.sup_flag & sup;
        if (has_result) begin
            nxt.phase = PH_OPC;
            if (st == ST_OK) begin
                nxt.sup_flag = sup_next;
            end else begin
                nxt.stopped = 1'b1;
            end
        end

        res.instr_offset     = start;
        res.opcode           = op;
        res.instr_length     = (st == ST_OK) ? len : '0;
        res.supported        = sup;
        res.is_jump          = jmp;
        res.jump_target      = (jmp && (st == ST_OK || st == ST_BAD_TGT)) ?
                               tgt[OFS_W-1:0] : '0;
        res.mark_target      = mt;
        res.mark_fallthrough = mf;
        res.status           = st;
        res.done_res         = (st != ST_OK) || last;
        res.all_supported    = nxt.sup_flag;
    end

endmodule
`default_nettype wire

>>> hdl/bytecode_length_and_leader_scan.sv
// Top level of the bytecode length and leader scanner: scan state and result registers.
//
//  channel | ports                    | carries
//  --------+--------------------------+-------------------------------------
//  input   | s_valid/s_ready          | one bytecode byte per transaction
//  result  | m_valid/m_ready          | one finished instruction or error
//  config  | cfg_wr_en/cfg_wr_data    | code_size; a write restarts the scan
//
// Bytes are decoded combinationally. The decode state advances at the edge that takes a
// byte; the output register is loaded at the edge that takes an instruction's last byte.
// s_ready stays high while the output register is empty or being drained, so bytes
// stream at one per cycle unless the result side stalls.
// Reset clears code_size to zero, so all bytes are ignored until it is written.
`default_nettype none
module bytecode_length_and_leader_scan (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire [bcls_pkg::OFS_W-1:0]    cfg_wr_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [7:0]                    s_code_byte,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [bcls_pkg::OFS_W-1:0]   m_instr_offset,
    output logic [7:0]                   m_opcode,
    output logic [bcls_pkg::OFS_W-1:0]   m_instr_length,
    output logic                         m_supported,
    output logic                         m_is_jump,
    output logic [bcls_pkg::OFS_W-1:0]   m_jump_target,
    output logic                         m_mark_target,
    output logic                         m_mark_fallthrough,
    output logic [2:0]                   m_status,
    output logic                         m_done_res,
    output logic                         m_all_supported
);
    import bcls_pkg::*;

    localparam scan_state_t STATE_RESET = '{
        pos: '0, start: '0, opc: 8'd0, phase: PH_OPC, acc: '0, left: '0,
        cases: 16'd0, sup_flag: 1'b1, stopped: 1'b0
    };

    scan_state_t      state_reg;
    scan_state_t      state_next;
    scan_result_t     res_reg;
    scan_result_t     res_next;
    logic             m_valid_reg;
    logic [OFS_W-1:0] code_size_reg;
    logic             has_result;
    logic             accept;
    logic             active;

    bcls_step u_step (
        .cur        (state_reg),
        .code_byte  (s_code_byte),
        .code_size  (code_size_reg),
        .nxt        (state_next),
        .has_result (has_result),
        .res        (res_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    // Bytes after an error or past the end of the function are dropped.
    assign active  = !state_reg.stopped && (state_reg.pos < code_size_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_RESET;
            code_size_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            state_reg     <= STATE_RESET;
            code_size_reg <= cfg_wr_data;
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end else begin
            if (accept && active) begin
                state_reg <= state_next;
            end
            if (accept && active && has_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && active && has_result) begin
            res_reg <= res_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_instr_offset     = res_reg.instr_offset;
    assign m_opcode           = res_reg.opcode;
    assign m_instr_length     = res_reg.instr_length;
    assign m_supported        = res_reg.supported;
    assign m_is_jump          = res_reg.is_jump;
    assign m_jump_target      = res_reg.jump_target;
    assign m_mark_target      = res_reg.mark_target;
    assign m_mark_fallthrough = res_reg.mark_fallthrough;
    assign m_status           = res_reg.status;
    assign m_done_res         = res_reg.done_res;
    assign m_all_supported    = res_reg.all_supported;

endmodule
`default_nettype wire

>>> test/tb_bytecode_length_and_leader_scan.sv
// Self-checking testbench for the bytecode length and leader scanner.
`default_nettype none
module tb_bytecode_length_and_leader_scan;
    import bcls_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [23:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_code_byte;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_instr_offset;
    logic [7:0]  m_opcode;
    logic [23:0] m_instr_length;
    logic        m_supported;
    logic        m_is_jump;
    logic [23:0] m_jump_target;
    logic        m_mark_target;
    logic        m_mark_fallthrough;
    logic [2:0]  m_status;
    logic        m_done_res;
    logic        m_all_supported;

    bytecode_length_and_leader_scan u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_code_byte(s_code_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_instr_offset(m_instr_offset), .m_opcode(m_opcode),
        .m_instr_length(m_instr_length), .m_supported(m_supported),
        .m_is_jump(m_is_jump), .m_jump_target(m_jump_target),
        .m_mark_target(m_mark_target), .m_mark_fallthrough(m_mark_fallthrough),
        .m_status(m_status), .m_done_res(m_done_res),
        .m_all_supported(m_all_supported)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Scanner state as the checker sees it.
    logic [23:0]  code_size;
    logic [23:0]  scan_pos;
    logic [23:0]  scan_start;
    logic [7:0]   scan_opc;
    phase_t       scan_phase;
    logic [23:0]  scan_acc;
    logic [23:0]  scan_left;
    logic [15:0]  scan_cases;
    bit           scan_sup;
    bit           scan_stopped;

    scan_result_t expected_instrs[$];
    logic [7:0]   body[$];
    int           errors = 0;
    bit           no_idle = 0;
    int           idle_cycles = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch in %s: got %0h, expected %0h", what, got, exp);
        errors++;
    endtask

    function automatic void restart_scan();
        scan_pos = '0; scan_start = '0; scan_opc = '0; scan_phase = PH_OPC;
        scan_acc = '0; scan_left = '0; scan_cases = '0;
        scan_sup = 1'b1; scan_stopped = 1'b0;
    endfunction

    // Advances the scan state by one byte; returns 1 when an instruction result is due.
    function automatic bit scan_byte(input logic [7:0] b, output scan_result_t r);
        logic [23:0] p;
        bit          last, complete, jmp, sup, mt, mf;
        status_t     st;
        logic [7:0]  info;
        logic [2:0]  kind;
        int unsigned hsz, idx, w;
        longint      start64, disp, t, len;
        logic [23:0] tgt;
        r = '0;
        if (scan_stopped || scan_pos >= code_size) return 1'b0;
        p = scan_pos;
        last = ({8'd0, p} + 32'd1 == {8'd0, code_size});
        scan_pos = p + 24'd1;
        if (scan_phase == PH_OPC) begin
            scan_start = p;
            scan_opc = b;
        end
        info = (scan_opc < 8'(ROM_SIZE)) ? OP_ROM[scan_opc] : 8'h00;
        kind = info[6:4];
        hsz = info[3:0];
        if (kind == KIND_FIX) hsz = hsz - 1;
        if (kind == KIND_SW) hsz = 2;
        start64 = scan_start;
        st = ST_OK;
        complete = 1'b0;
        case (scan_phase)
            PH_OPC: begin
                scan_acc = '0;
                if (kind == KIND_UNK || kind > KIND_SW) begin
                    st = ST_UNKNOWN;
                end else if (kind == KIND_FIX) begin
                    if (start64 + hsz + 1 > code_size) st = ST_TRUNCATED;
                    else if (hsz == 0) complete = 1'b1;
                    else begin
                        scan_phase = PH_OPND; scan_left = hsz;
                    end
                end else begin
                    scan_phase = PH_HDR; scan_left = hsz;
                end
            end
            PH_OPND, PH_HDR: begin
                idx = (hsz - scan_left) & 3;
                scan_acc = scan_acc | (24'(b) << (8 * idx));
                scan_left--;
                if (scan_left == 0) begin
                    if (scan_phase == PH_OPND) begin
                        complete = 1'b1;
                    end else if (kind == KIND_STR) begin
                        if (start64 + 1 + hsz + scan_acc > code_size) st = ST_TRUNCATED;
                        else if (scan_acc == 0) complete = 1'b1;
                        else begin
                            scan_phase = PH_SKIP; scan_left = scan_acc;
                        end
                    end else if (kind == KIND_BLK) begin
                        if (scan_acc < 1 + hsz) st = ST_UNKNOWN;
                        else if (start64 + scan_acc > code_size) st = ST_TRUNCATED;
                        else if (scan_acc == 1 + hsz) complete = 1'b1;
                        else begin
                            scan_phase = PH_SKIP; scan_left = scan_acc - 1 - hsz;
                        end
                    end else begin
                        scan_cases = scan_acc[15:0];
                        if (scan_cases == 0) complete = 1'b1;
                        else scan_phase = PH_SWLIT;
                    end
                end
            end
            PH_SKIP: begin
                scan_left--;
                if (scan_left == 0) complete = 1'b1;
            end
            PH_SWLIT: begin
                if (b == SW_LIT_NUM) begin
                    scan_phase = PH_SWLSKIP; scan_left = 4;
                end else if (b == SW_LIT_STR) scan_phase = PH_SWSTRLEN;
                else if (b == SW_LIT_NIL) scan_phase = PH_SWJMP;
                else st = ST_BAD_SW;
            end
            PH_SWLSKIP: begin
                scan_left--;
                if (scan_left == 0) scan_phase = PH_SWJMP;
            end
            PH_SWSTRLEN: begin
                if (b == 0) scan_phase = PH_SWJMP;
                else begin
                    scan_phase = PH_SWLSKIP; scan_left = b;
                end
            end
            PH_SWJMP: begin
                if (b >= OP_JMP_FIRST && b <= OP_JMP_SW_LAST) begin
                    scan_phase = PH_SWJSKIP; scan_left = b - SW_JMP_BIAS;
                end else st = ST_BAD_SW;
            end
            PH_SWJSKIP: begin
                scan_left--;
                if (scan_left == 0) begin
                    scan_cases--;
                    if (scan_cases == 0) complete = 1'b1;
                    else scan_phase = PH_SWLIT;
                end
            end
            default: st = ST_UNKNOWN;
        endcase
        if (st == ST_OK && !complete && last) st = ST_TRUNCATED;
        if (st == ST_OK && !complete) return 1'b0;

        jmp = scan_opc >= OP_JMP_FIRST && scan_opc <= OP_JMP_LAST;
        sup = info[7];
        len = longint'(p) + 1 - start64;
        tgt = '0; mt = 1'b0; mf = 1'b0;
        if (st == ST_OK && jmp) begin
            w = 8 * (hsz & 3);
            disp = longint'(scan_acc) & ((64'sd1 << w) - 1);
            if (w != 0 && scan_acc[w-1]) disp -= (64'sd1 << w);
            t = start64 + disp;
            tgt = t[23:0];
            if (t < 0 || t > code_size) st = ST_BAD_TGT;
            else begin
                mt = t < code_size;
                mf = start64 + len < code_size;
            end
        end
        if (st == ST_OK) scan_sup = scan_sup && sup;
        else scan_stopped = 1'b1;
        if ((st != ST_OK && st != ST_BAD_TGT) || !jmp) tgt = '0;

        r.instr_offset = scan_start;
        r.opcode = scan_opc;
        r.instr_length = (st == ST_OK) ? len[23:0] : 24'd0;
        r.supported = sup;
        r.is_jump = jmp;
        r.jump_target = tgt;
        r.mark_target = mt;
        r.mark_fallthrough = mf;
        r.status = st;
        r.done_res = (st != ST_OK) || last;
        r.all_supported = scan_sup;
        scan_phase = PH_OPC;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Called at a rising edge; returns at the edge where the byte is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        scan_result_t r;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_code_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (scan_byte(b, r)) expected_instrs.push_back(r);
    endtask

    task automatic write_code_size(input logic [23:0] size);
        s_valid <= 1'b0;
        while (expected_instrs.size() != 0) @(posedge aclk);
        // A byte that finished no instruction may still be settling.
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        code_size = size;
        restart_scan();
    endtask

    task automatic run_body(input logic [23:0] size);
        write_code_size(size);
        foreach (body[i]) send_byte(body[i]);
        body.delete();
    endtask

    task automatic push_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) body.push_back(v[8*i +: 8]);
    endtask

    // Appends one well-formed instruction with random operands.
    task automatic add_instr(input logic [7:0] op);
        logic [7:0] info;
        int hsz, off, n, lit, jop;
        longint disp;
        info = (op < 8'(ROM_SIZE)) ? OP_ROM[op] : 8'h00;
        hsz = info[3:0];
        off = body.size();
        body.push_back(op);
        case (info[6:4])
            KIND_FIX: begin
                if (op >= OP_JMP_FIRST && op <= OP_JMP_LAST) begin
                    if ($urandom_range(0, 9) < 8) disp = -longint'($urandom_range(0, off));
                    else disp = $urandom_range(0, 20);
                    if (hsz == 2 && disp < -128) disp = -128;
                    push_le(32'(disp), hsz - 1);
                end else begin
                    for (int i = 1; i < hsz; i++) body.push_back(8'($urandom));
                end
            end
            KIND_STR: begin
                n = $urandom_range(0, 5);
                push_le(n, hsz);
                repeat (n) body.push_back(8'($urandom));
            end
            KIND_BLK: begin
                n = $urandom_range(0, 5);
                push_le(1 + hsz + n, hsz);
                repeat (n) body.push_back(8'($urandom));
            end
            KIND_SW: begin
                n = $urandom_range(0, 3);
                push_le(n, 2);
                repeat (n) begin
                    lit = $urandom_range(0, 2);
                    if (lit == 0) begin
                        body.push_back(SW_LIT_NUM);
                        repeat (4) body.push_back(8'($urandom));
                    end else if (lit == 1) begin
                        body.push_back(SW_LIT_STR);
                        lit = $urandom_range(0, 3);
                        body.push_back(8'(lit));
                        repeat (lit) body.push_back(8'($urandom));
                    end else begin
                        body.push_back(SW_LIT_NIL);
                    end
                    jop = $urandom_range(OP_JMP_FIRST, OP_JMP_SW_LAST);
                    body.push_back(8'(jop));
                    repeat (jop - SW_JMP_BIAS) body.push_back(8'($urandom));
                end
            end
            default: ;
        endcase
    endtask

    // Mostly known opcodes; an unknown one now and then stops the scan.
    function automatic logic [7:0] pick_opcode();
        logic [7:0] op;
        int tries;
        tries = 0;
        do begin
            op = ($urandom_range(0, 99) < 30) ? 8'($urandom_range(OP_JMP_FIRST, OP_JMP_LAST))
                                              : 8'($urandom_range(0, ROM_SIZE - 1));
            tries++;
        end while (OP_ROM[op][6:4] == KIND_UNK && tries < 20);
        if ($urandom_range(0, 199) == 0) op = 8'($urandom_range(ROM_SIZE, 255));
        return op;
    endfunction

    always @(posedge aclk) begin
        int hold;
        if (!aresetn || no_idle) begin
            m_ready <= 1'b1;
            hold = 0;
        end else if (hold > 0) begin
            hold--;
        end else begin
            m_ready <= $urandom_range(0, 2) != 0;
            hold = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
    end

    always @(posedge aclk) begin
        scan_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_instrs.size() == 0) begin
                report("unexpected result at offset", m_instr_offset, 0);
            end else begin
                e = expected_instrs.pop_front();
                if (m_instr_offset !== e.instr_offset)
                    report("instr_offset", m_instr_offset, e.instr_offset);
                if (m_opcode !== e.opcode) report("opcode", m_opcode, e.opcode);
                if (m_instr_length !== e.instr_length)
                    report("instr_length", m_instr_length, e.instr_length);
                if (m_supported !== e.supported) report("supported", m_supported, e.supported);
                if (m_is_jump !== e.is_jump) report("is_jump", m_is_jump, e.is_jump);
                if (m_jump_target !== e.jump_target)
                    report("jump_target", m_jump_target, e.jump_target);
                if (m_mark_target !== e.mark_target)
                    report("mark_target", m_mark_target, e.mark_target);
                if (m_mark_fallthrough !== e.mark_fallthrough)
                    report("mark_fallthrough", m_mark_fallthrough, e.mark_fallthrough);
                if (m_status !== e.status) report("status", m_status, e.status);
                if (m_done_res !== e.done_res) report("done_res", m_done_res, e.done_res);
                if (m_all_supported !== e.all_supported)
                    report("all_supported", m_all_supported, e.all_supported);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_before_config();
        // code_size resets to zero, so these bytes must be ignored.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h19);
    endtask

    task automatic test_jumps();
        body = '{8'd0, 8'd25, 8'hFF, 8'd26, 8'h03, 8'h00, 8'd27, 8'hFA, 8'hFF, 8'hFF};
        run_body(10);
        // A target equal to code_size is legal but not marked.
        body = '{8'd0, 8'd25, 8'h02};
        run_body(3);
        body = '{8'd25, 8'hFE};
        run_body(2);
    endtask

    task automatic test_errors();
        body = '{8'd37, 8'd0};
        run_body(2);
        body = '{8'd255, 8'd0, 8'd0};
        run_body(3);
        body = '{8'd89, 8'd2, 8'd0};
        run_body(3);
        body = '{8'd3};
        run_body(2);
        body = '{8'd133, 8'd1, 8'd0, SW_LIT_NIL};
        run_body(4);
        body = '{8'd133, 8'd1, 8'd0, 8'd50};
        run_body(4);
        body = '{8'd133, 8'd1, 8'd0, SW_LIT_NIL, 8'd30};
        run_body(5);
    endtask

    task automatic test_variable_forms();
        body = '{8'd133, 8'd3, 8'd0, SW_LIT_NUM, 8'd1, 8'd2, 8'd3, 8'd4, 8'd25, 8'd9,
                 SW_LIT_STR, 8'd2, 8'd7, 8'd7, 8'd27, 8'd1, 8'd2, 8'd3,
                 SW_LIT_NIL, 8'd26, 8'd1, 8'd2,
                 8'd106, 8'd3, 8'd1, 8'd2, 8'd3, 8'd106, 8'd0, 8'd89, 8'd5, 8'd0, 8'd9, 8'd9};
        run_body(24'(body.size()));
    endtask

    task automatic test_max_size();
        body.push_back(8'd101);
        repeat (10) body.push_back(8'($urandom));
        body = {body, 8'd27, 8'hFF, 8'hFF, 8'h7F, 8'd0};
        run_body(24'hFFFFFF);
        write_code_size(24'd0);
        send_byte(8'd0);
    endtask

    task automatic test_random_functions(input int total);
        int sent, n, r;
        logic [23:0] size;
        sent = 0;
        while (sent < total) begin
            n = $urandom_range(1, 8);
            repeat (n) add_instr(pick_opcode());
            r = $urandom_range(0, 99);
            if (r < 75) size = 24'(body.size());
            else if (r < 90) size = 24'($urandom_range(1, body.size()));
            else begin
                size = 24'(body.size() + $urandom_range(1, 6));
                repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
            end
            // Some extra trailing bytes; any that lie past code_size the block must drop.
            if ($urandom_range(0, 9) == 0) repeat (3) body.push_back(8'($urandom));
            sent += body.size();
            run_body(size);
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_code_byte <= '0;
        code_size = '0;
        restart_scan();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_before_config();
        test_jumps();
        test_errors();
        test_variable_forms();
        test_max_size();
        test_random_functions(500);
        no_idle = 1;
        test_random_functions(150);
        no_idle = 0;

        s_valid <= 1'b0;
        while (expected_instrs.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
